### rtl/two_channel_ppm_pulse_generator_assert.svh
// assertion macros for the rtl modules, included by the controller
`ifndef TWO_CHANNEL_PPM_PULSE_GENERATOR_ASSERT_SVH
`define TWO_CHANNEL_PPM_PULSE_GENERATOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TCPG_ASSERT_IMPLY(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define TCPG_ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

### rtl/tcpg_pkg.sv
// shared types and constants of the ppm pulse generator
package tcpg_pkg;

   localparam int LEVEL_W = 16;
   localparam int CFG_W   = 13;
   localparam int IDX_W   = 3;
   localparam int WIDTH_W = 11;
   localparam int TICK_W  = 11;
   localparam int PROD_W  = 2 * CFG_W;
   localparam int SUM_W   = 16;

   // quotient never exceeds the magnitude of max - min, so 13 steps suffice
   localparam int DIV_STEPS = CFG_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

   localparam logic [WIDTH_W-1:0] WIDTH_FLOOR  = 11'd1000;
   localparam logic [WIDTH_W-1:0] WIDTH_CEIL   = 11'd2000;
   localparam logic [WIDTH_W-1:0] WIDTH_CENTER = 11'd1500;

   localparam logic [CFG_W-1:0] INPUT_MAX_RESET = 13'd255;
   localparam logic [CFG_W-1:0] MIN_WIDTH_RESET = 13'd1000;
   localparam logic [CFG_W-1:0] MAX_WIDTH_RESET = 13'd2000;

   typedef enum logic {
      ACT_TICK = 1'b0,
      ACT_SET  = 1'b1
   } action_type;

   typedef enum logic [IDX_W-1:0] {
      CFG_INPUT_MAX     = 3'd0,
      CFG_MIN_WIDTH     = 3'd1,
      CFG_MAX_WIDTH     = 3'd2,
      CFG_INVERT_FIRST  = 3'd3,
      CFG_INVERT_SECOND = 3'd4
   } cfg_index_type;

   typedef struct packed {
      logic tick;
      logic capture;
      logic mul;
      logic div_step;
      logic write_width;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

### rtl/tcpg_req_if.sv
// request channel: tick and set items
interface tcpg_req_if;
   import tcpg_pkg::*;

   logic               valid;
   logic               ready;
   logic               action;
   logic               channel;
   logic               has_level;
   logic [LEVEL_W-1:0] level;

   modport source (output valid, action, channel, has_level, level, input ready);
   modport sink   (input valid, action, channel, has_level, level, output ready);
endinterface

### rtl/tcpg_rsp_if.sv
// response channel: pin levels and stored widths
interface tcpg_rsp_if;
   import tcpg_pkg::*;

   logic               valid;
   logic               ready;
   logic               first_pin;
   logic               second_pin;
   logic [WIDTH_W-1:0] first_width;
   logic [WIDTH_W-1:0] second_width;

   modport source (output valid, first_pin, second_pin, first_width, second_width,
                   input ready);
   modport sink   (input valid, first_pin, second_pin, first_width, second_width,
                   output ready);
endinterface

### rtl/tcpg_scale_dp.sv
// config registers and level-to-width scaler with iterative divider
module tcpg_scale_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  tcpg_pkg::cmd_type             cmd,
   input  logic                          csr_we,
   input  logic [tcpg_pkg::IDX_W-1:0]    csr_index,
   input  logic [tcpg_pkg::CFG_W-1:0]    csr_data,
   input  logic                          req_channel,
   input  logic                          req_has_level,
   input  logic [tcpg_pkg::LEVEL_W-1:0]  req_level,
   output logic                          wr_channel,
   output logic [tcpg_pkg::WIDTH_W-1:0]  wr_width
);
   import tcpg_pkg::*;

   logic [CFG_W-1:0] input_max_ff, min_width_ff, max_width_ff;
   logic             invert_first_ff, invert_second_ff;

   logic [CFG_W-1:0]  full, half, lvl, fsel, dmag;
   logic [CFG_W:0]    diff;
   logic              inv;

   logic [CFG_W-1:0]  full_ff, f_ff, dmag_ff, rem_ff, quo_ff;
   logic [CFG_W-1:0]  full_in, f_in, dmag_in, rem_in, quo_in;
   logic              neg_ff, neg_in, chan_ff, chan_in;

   logic [PROD_W-1:0] product;
   logic [CFG_W:0]    trial;
   logic              fits;

   logic              round;
   logic signed [SUM_W-1:0] min_s, quo_s, wsum;

   always_ff @(posedge clock) begin
      if (reset) begin
         input_max_ff     <= INPUT_MAX_RESET;
         min_width_ff     <= MIN_WIDTH_RESET;
         max_width_ff     <= MAX_WIDTH_RESET;
         invert_first_ff  <= 1'b0;
         invert_second_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (cfg_index_type'(csr_index))
            CFG_INPUT_MAX:     input_max_ff     <= csr_data;
            CFG_MIN_WIDTH:     min_width_ff     <= csr_data;
            CFG_MAX_WIDTH:     max_width_ff     <= csr_data;
            CFG_INVERT_FIRST:  invert_first_ff  <= csr_data[0];
            CFG_INVERT_SECOND: invert_second_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // operand preparation for a set item
   always_comb begin
      full = (input_max_ff == '0) ? CFG_W'(1) : input_max_ff;
      half = full >> 1;
      if (req_has_level) begin
         lvl = (req_level > {{(LEVEL_W-CFG_W){1'b0}}, full}) ? full : req_level[CFG_W-1:0];
      end else begin
         lvl = half;
      end
      inv  = req_channel ? invert_second_ff : invert_first_ff;
      fsel = inv ? (full - lvl) : lvl;
      diff = {1'b0, max_width_ff} - {1'b0, min_width_ff};
      dmag = diff[CFG_W] ? CFG_W'((CFG_W+1)'(0) - diff) : diff[CFG_W-1:0];
   end

   assign product = {{CFG_W{1'b0}}, dmag_ff} * {{CFG_W{1'b0}}, f_ff};

   // restoring divide, one quotient bit per step
   assign trial = {rem_ff, quo_ff[CFG_W-1]};
   assign fits  = (trial >= {1'b0, full_ff});

   always_comb begin
      full_in = full_ff;
      f_in    = f_ff;
      dmag_in = dmag_ff;
      neg_in  = neg_ff;
      chan_in = chan_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (cmd.capture) begin
         full_in = full;
         f_in    = fsel;
         dmag_in = dmag;
         neg_in  = diff[CFG_W];
         chan_in = req_channel;
      end
      if (cmd.mul) begin
         rem_in = product[PROD_W-1:CFG_W];
         quo_in = product[CFG_W-1:0];
      end
      if (cmd.div_step) begin
         rem_in = fits ? CFG_W'(trial - {1'b0, full_ff}) : trial[CFG_W-1:0];
         quo_in = {quo_ff[CFG_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      full_ff <= full_in;
      f_ff    <= f_in;
      dmag_ff <= dmag_in;
      neg_ff  <= neg_in;
      chan_ff <= chan_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   // floor toward minus infinity for a negative span, then clamp
   always_comb begin
      round = neg_ff & (rem_ff != '0);
      min_s = $signed({{(SUM_W-CFG_W){1'b0}}, min_width_ff});
      quo_s = $signed({{(SUM_W-CFG_W){1'b0}}, quo_ff});
      if (neg_ff) begin
         wsum = min_s - quo_s - $signed({{(SUM_W-1){1'b0}}, round});
      end else begin
         wsum = min_s + quo_s;
      end
      if (wsum < $signed({{(SUM_W-WIDTH_W){1'b0}}, WIDTH_FLOOR})) begin
         wr_width = WIDTH_FLOOR;
      end else if (wsum > $signed({{(SUM_W-WIDTH_W){1'b0}}, WIDTH_CEIL})) begin
         wr_width = WIDTH_CEIL;
      end else begin
         wr_width = wsum[WIDTH_W-1:0];
      end
   end

   assign wr_channel = chan_ff;

endmodule

### rtl/tcpg_chan_dp.sv
// per-channel pulse counters, stored widths and response register
module tcpg_chan_dp #(
   parameter int CHANNELS        = 2,
   parameter int LOW_PULSE_TICKS = 400
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tcpg_pkg::cmd_type            cmd,
   output tcpg_pkg::status_type         status,
   input  logic                         wr_channel,
   input  logic [tcpg_pkg::WIDTH_W-1:0] wr_width,
   tcpg_rsp_if.source                   rsp_bus
);
   import tcpg_pkg::*;

   localparam logic [TICK_W-1:0] LOW_TICKS = TICK_W'(LOW_PULSE_TICKS);

   logic [CHANNELS-1:0] pin_vec;
   logic [WIDTH_W-1:0]  period_arr [CHANNELS];

   for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
      logic [TICK_W-1:0]  cnt_ff, cnt_in, cnt_inc, target_ff, target_in;
      logic [WIDTH_W-1:0] period_ff, period_in;
      logic               phase_ff, phase_in, pin_ff, pin_in;

      always_comb begin
         cnt_inc   = cnt_ff + TICK_W'(1);
         cnt_in    = cnt_ff;
         target_in = target_ff;
         phase_in  = phase_ff;
         pin_in    = pin_ff;
         period_in = period_ff;
         if (cmd.tick) begin
            if (cnt_inc >= target_ff) begin
               cnt_in = '0;
               if (phase_ff) begin
                  // low phase over: go high for the rest of the period
                  pin_in    = 1'b1;
                  target_in = TICK_W'(period_ff - LOW_TICKS);
                  phase_in  = 1'b0;
               end else begin
                  pin_in    = 1'b0;
                  target_in = LOW_TICKS;
                  phase_in  = 1'b1;
               end
            end else begin
               cnt_in = cnt_inc;
            end
         end
         if (cmd.write_width && (32'(wr_channel) == c)) begin
            period_in = wr_width;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cnt_ff    <= '0;
            target_ff <= LOW_TICKS;
            phase_ff  <= 1'b0;
            pin_ff    <= 1'b0;
            period_ff <= WIDTH_CENTER;
         end else begin
            cnt_ff    <= cnt_in;
            target_ff <= target_in;
            phase_ff  <= phase_in;
            pin_ff    <= pin_in;
            period_ff <= period_in;
         end
      end

      assign pin_vec[c]    = pin_ff;
      assign period_arr[c] = period_ff;
   end

   logic               second_pin;
   logic [WIDTH_W-1:0] second_width;

   if (CHANNELS > 1) begin : g_second
      assign second_pin   = pin_vec[1];
      assign second_width = period_arr[1];
   end else begin : g_no_second
      assign second_pin   = 1'b0;
      assign second_width = WIDTH_CENTER;
   end

   // response register, refilled as soon as the held transfer goes out
   logic               rsp_valid_ff, rsp_valid_in;
   logic               first_pin_ff, second_pin_ff;
   logic [WIDTH_W-1:0] first_width_ff, second_width_ff;

   assign status.out_free = ~rsp_valid_ff | rsp_bus.ready;
   assign rsp_valid_in    = cmd.load_out | (rsp_valid_ff & ~rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         first_pin_ff    <= pin_vec[0];
         second_pin_ff   <= second_pin;
         first_width_ff  <= period_arr[0];
         second_width_ff <= second_width;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.first_pin    = first_pin_ff;
   assign rsp_bus.second_pin   = second_pin_ff;
   assign rsp_bus.first_width  = first_width_ff;
   assign rsp_bus.second_width = second_width_ff;

endmodule

### rtl/tcpg_ctrl.sv
// controller: sequences tick, capture, multiply, divide, width write and report steps
`include "two_channel_ppm_pulse_generator_assert.svh"

module tcpg_ctrl #(
   parameter int CHANNELS = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_action,
   input  logic                 req_channel,
   output logic                 req_ready,
   input  tcpg_pkg::status_type status,
   output tcpg_pkg::cmd_type    cmd
);
   import tcpg_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_FIN,
      ST_REPORT
   } state_type;

   state_type         state_ff;
   logic              ready_ff;
   logic [STEP_W-1:0] step_ff;
   logic              accept, present;

   assign accept    = req_valid & ready_ff;
   assign present   = (32'(req_channel) < CHANNELS);
   assign req_ready = ready_ff;

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (action_type'(req_action) == ACT_TICK) begin
                  cmd.tick = 1'b1;
               end else if (present) begin
                  cmd.capture = 1'b1;
               end
            end
         end
         ST_MUL:    cmd.mul         = 1'b1;
         ST_DIV:    cmd.div_step    = 1'b1;
         ST_FIN:    cmd.write_width = 1'b1;
         ST_REPORT: cmd.load_out    = status.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
         step_ff  <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  ready_ff <= 1'b0;
                  // a set item for an absent channel only reports
                  if (cmd.capture) begin
                     state_ff <= ST_MUL;
                  end else begin
                     state_ff <= ST_REPORT;
                  end
               end
            end
            ST_MUL: begin
               step_ff  <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (step_ff == STEP_LAST) begin
                  state_ff <= ST_FIN;
               end else begin
                  step_ff <= step_ff + STEP_W'(1);
               end
            end
            ST_FIN: state_ff <= ST_REPORT;
            ST_REPORT: begin
               if (status.out_free) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

   `TCPG_ASSERT_IMPLY(a_ready_only_idle, ready_ff, state_ff == ST_IDLE, "ready outside idle")
   `TCPG_ASSERT_NEXT(a_capture_to_mul, cmd.capture, state_ff == ST_MUL, "set item did not start")
   `TCPG_ASSERT_IMPLY(a_load_when_free, cmd.load_out, status.out_free, "response overwritten")
   `TCPG_ASSERT_NEXT(a_div_ends, (state_ff == ST_DIV) && (step_ff == STEP_LAST),
                     state_ff == ST_FIN, "divide did not finish")

endmodule

### rtl/two_channel_ppm_pulse_generator.sv
// two-channel ppm pulse generator top level
//
// req_bus carries one item per transfer: a one-microsecond tick (action 0)
// or a set item (action 1) that turns a command level into the stored
// pulse period of one channel. rsp_bus returns exactly one transfer per
// item: both pin levels and both stored periods after the update.
// csr_we/csr_index/csr_data write input_max, min_width, max_width and the
// two invert bits; write them only while no item is in flight.
//
// a tick updates the channel counters at acceptance; the response register
// loads in the report state once it is free. a set item runs through
// acceptance, a multiply step, the one-bit-per-cycle restoring divider,
// a step to clamp and store the period and a step to load the response.
// set items for an absent channel go straight to the report step.
// reset restores the register defaults, a 1500 tick period and a low pin
// in every channel, and empties the response register. when the receiver
// stalls the response is held and the next item waits at the report step.
module two_channel_ppm_pulse_generator #(
   parameter int CHANNELS        = 2,
   parameter int LOW_PULSE_TICKS = 400
) (
   input  logic                       clock,
   input  logic                       reset,
   tcpg_req_if.sink                   req_bus,
   tcpg_rsp_if.source                 rsp_bus,
   input  logic                       csr_we,
   input  logic [tcpg_pkg::IDX_W-1:0] csr_index,
   input  logic [tcpg_pkg::CFG_W-1:0] csr_data
);
   import tcpg_pkg::*;

   cmd_type            cmd;
   status_type         status;
   logic               wr_channel;
   logic [WIDTH_W-1:0] wr_width;

   tcpg_ctrl #(
      .CHANNELS (CHANNELS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_action  (req_bus.action),
      .req_channel (req_bus.channel),
      .req_ready   (req_bus.ready),
      .status      (status),
      .cmd         (cmd)
   );

   tcpg_scale_dp u_scale (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_channel   (req_bus.channel),
      .req_has_level (req_bus.has_level),
      .req_level     (req_bus.level),
      .wr_channel    (wr_channel),
      .wr_width      (wr_width)
   );

   tcpg_chan_dp #(
      .CHANNELS        (CHANNELS),
      .LOW_PULSE_TICKS (LOW_PULSE_TICKS)
   ) u_chan (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .wr_channel (wr_channel),
      .wr_width   (wr_width),
      .rsp_bus    (rsp_bus)
   );

endmodule

### sim/tb_two_channel_ppm_pulse_generator.sv
// testbench for the two-channel ppm pulse generator: directed table, random phases, scoreboard
module tb_two_channel_ppm_pulse_generator;
   import tcpg_pkg::*;

   localparam int CHANNELS        = 2;
   localparam int LOW_PULSE_TICKS = 400;
   localparam int NUM_PHASES      = 7;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int HOLD_CYCLES     = 300;
   localparam int STALL_LIMIT     = 5000;
   localparam int DRAIN_CYCLES    = 20;

   typedef struct packed {
      logic               first_pin;
      logic               second_pin;
      logic [WIDTH_W-1:0] first_width;
      logic [WIDTH_W-1:0] second_width;
   } ppm_report_type;

   typedef struct packed {
      logic               is_cfg;
      cfg_index_type      reg_index;
      logic [CFG_W-1:0]   reg_value;
      action_type         act;
      logic               chan;
      logic               has_lvl;
      logic [LEVEL_W-1:0] lvl;
      logic               typed;
      ppm_report_type     want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic               csr_we;
   logic [IDX_W-1:0]   csr_index;
   logic [CFG_W-1:0]   csr_data;

   tcpg_req_if req_bus ();
   tcpg_rsp_if rsp_bus ();

   two_channel_ppm_pulse_generator #(
      .CHANNELS        (CHANNELS),
      .LOW_PULSE_TICKS (LOW_PULSE_TICKS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #6 clock = ~clock;

   // predictor copy of the registers and channel state
   logic [CFG_W-1:0]   cfg_full_scale;
   logic [CFG_W-1:0]   cfg_min_width;
   logic [CFG_W-1:0]   cfg_max_width;
   logic               cfg_invert [CHANNELS];
   logic [WIDTH_W-1:0] period_reg [CHANNELS];
   logic               in_low_pulse [CHANNELS];
   logic [TICK_W-1:0]  tick_cnt [CHANNELS];
   logic [TICK_W-1:0]  alarm_at [CHANNELS];
   logic               pin_lvl [CHANNELS];

   ppm_report_type awaited_reports [$];
   stim_row_type   directed_rows [$];
   int          fail_count   = 0;
   int          src_gap_max  = 15;
   int          snk_gap_max  = 15;
   bit          hold_request = 1'b0;

   function automatic void advance_tick(int c);
      tick_cnt[c] = tick_cnt[c] + TICK_W'(1);
      if (tick_cnt[c] >= alarm_at[c]) begin
         tick_cnt[c] = '0;
         if (in_low_pulse[c]) begin
            pin_lvl[c]      = 1'b1;
            alarm_at[c]     = period_reg[c] - TICK_W'(LOW_PULSE_TICKS);
            in_low_pulse[c] = 1'b0;
         end else begin
            pin_lvl[c]      = 1'b0;
            alarm_at[c]     = TICK_W'(LOW_PULSE_TICKS);
            in_low_pulse[c] = 1'b1;
         end
      end
   endfunction

   function automatic logic [WIDTH_W-1:0] scaled_period(logic has, logic [LEVEL_W-1:0] lvl,
                                                         logic inv);
      longint full, v, f, prod, q, w;
      full = (cfg_full_scale == '0) ? 64'sd1 : longint'(cfg_full_scale);
      v = has ? longint'(lvl) : full / 2;
      if (v > full) v = full;
      f = inv ? full - v : v;
      prod = (longint'(cfg_max_width) - longint'(cfg_min_width)) * f;
      q = prod / full;
      // round toward minus infinity when max is below min
      if (prod < 0 && q * full != prod) q = q - 1;
      w = q + longint'(cfg_min_width);
      if (w < longint'(WIDTH_FLOOR)) w = longint'(WIDTH_FLOOR);
      if (w > longint'(WIDTH_CEIL)) w = longint'(WIDTH_CEIL);
      return w[WIDTH_W-1:0];
   endfunction

   function automatic ppm_report_type apply_item(action_type act, logic ch, logic has,
                                                 logic [LEVEL_W-1:0] lvl);
      ppm_report_type r;
      if (act == ACT_TICK) begin
         for (int c = 0; c < CHANNELS; c++) advance_tick(c);
      end else begin
         period_reg[ch] = scaled_period(has, lvl, cfg_invert[ch]);
      end
      r.first_pin    = pin_lvl[0];
      r.second_pin   = pin_lvl[1];
      r.first_width  = period_reg[0];
      r.second_width = period_reg[1];
      return r;
   endfunction

   function automatic stim_row_type item_row(action_type act, logic ch, logic has,
                                             logic [LEVEL_W-1:0] lvl);
      stim_row_type r;
      r = '0;
      r.act     = act;
      r.chan    = ch;
      r.has_lvl = has;
      r.lvl     = lvl;
      return r;
   endfunction

   function automatic stim_row_type checked_row(action_type act, logic ch, logic has,
                                                logic [LEVEL_W-1:0] lvl, logic p0, logic p1,
                                                logic [WIDTH_W-1:0] w0,
                                                logic [WIDTH_W-1:0] w1);
      stim_row_type r;
      r = item_row(act, ch, has, lvl);
      r.typed = 1'b1;
      r.want  = '{p0, p1, w0, w1};
      return r;
   endfunction

   function automatic stim_row_type cfg_row(cfg_index_type idx, logic [CFG_W-1:0] value);
      stim_row_type r;
      r = '0;
      r.is_cfg    = 1'b1;
      r.reg_index = idx;
      r.reg_value = value;
      return r;
   endfunction

   // mostly within lo..hi, now and then zero, one or all ones in the 13-bit field
   function automatic logic [CFG_W-1:0] pick_setting(int lo, int hi);
      int sel;
      sel = $urandom_range(0, 7);
      if (sel == 0) return '0;
      if (sel == 1) return '1;
      if (sel == 2) return CFG_W'(1);
      return CFG_W'($urandom_range(lo, hi));
   endfunction

   task automatic wait_until_drained();
      req_bus.valid <= 1'b0;
      while (awaited_reports.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(cfg_index_type idx, logic [CFG_W-1:0] value);
      wait_until_drained();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CFG_INPUT_MAX:     cfg_full_scale = value;
         CFG_MIN_WIDTH:     cfg_min_width  = value;
         CFG_MAX_WIDTH:     cfg_max_width  = value;
         CFG_INVERT_FIRST:  cfg_invert[0]  = value[0];
         CFG_INVERT_SECOND: cfg_invert[1]  = value[0];
         default: ;
      endcase
   endtask

   // valid stays high after a transfer when the next gap is zero
   task automatic send_item(action_type act, logic ch, logic has, logic [LEVEL_W-1:0] lvl,
                            logic typed, ppm_report_type typed_want);
      int gap;
      ppm_report_type predicted;
      gap = $urandom_range(0, src_gap_max);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.action    <= act;
      req_bus.channel   <= ch;
      req_bus.has_level <= has;
      req_bus.level     <= lvl;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = apply_item(act, ch, has, lvl);
      awaited_reports.push_back(typed ? typed_want : predicted);
   endtask

   initial begin : stimulus
      action_type         act;
      logic               ch;
      logic               has;
      logic [LEVEL_W-1:0] lvl;

      req_bus.valid     <= 1'b0;
      req_bus.action    <= ACT_TICK;
      req_bus.channel   <= 1'b0;
      req_bus.has_level <= 1'b0;
      req_bus.level     <= '0;
      csr_we            <= 1'b0;
      csr_index         <= CFG_INPUT_MAX;
      csr_data          <= '0;

      cfg_full_scale = INPUT_MAX_RESET;
      cfg_min_width  = MIN_WIDTH_RESET;
      cfg_max_width  = MAX_WIDTH_RESET;
      for (int c = 0; c < CHANNELS; c++) begin
         cfg_invert[c]   = 1'b0;
         period_reg[c]   = WIDTH_CENTER;
         in_low_pulse[c] = 1'b0;
         tick_cnt[c]     = '0;
         alarm_at[c]     = TICK_W'(LOW_PULSE_TICKS);
         pin_lvl[c]      = 1'b0;
      end

      // reset defaults first, then inversion, zero full scale, max below min, extremes
      directed_rows.push_back(checked_row(ACT_TICK, 1'b0, 1'b0, 16'h0000,
                                          1'b0, 1'b0, WIDTH_CENTER, WIDTH_CENTER));
      directed_rows.push_back(checked_row(ACT_SET, 1'b0, 1'b1, 16'h0000,
                                          1'b0, 1'b0, WIDTH_FLOOR, WIDTH_CENTER));
      directed_rows.push_back(checked_row(ACT_SET, 1'b1, 1'b1, 16'hFFFF,
                                          1'b0, 1'b0, WIDTH_FLOOR, WIDTH_CEIL));
      directed_rows.push_back(checked_row(ACT_TICK, 1'b1, 1'b1, 16'hFFFF,
                                          1'b0, 1'b0, WIDTH_FLOOR, WIDTH_CEIL));
      directed_rows.push_back(item_row(ACT_SET, 1'b0, 1'b0, 16'hFFFF));
      directed_rows.push_back(item_row(ACT_SET, 1'b1, 1'b1, 16'd256));
      directed_rows.push_back(cfg_row(CFG_INVERT_FIRST, 13'd1));
      directed_rows.push_back(checked_row(ACT_SET, 1'b0, 1'b1, 16'h0000,
                                          1'b0, 1'b0, WIDTH_CEIL, WIDTH_CEIL));
      directed_rows.push_back(cfg_row(CFG_INVERT_SECOND, 13'd1));
      directed_rows.push_back(checked_row(ACT_SET, 1'b1, 1'b1, 16'hFFFF,
                                          1'b0, 1'b0, WIDTH_CEIL, WIDTH_FLOOR));
      directed_rows.push_back(cfg_row(CFG_INPUT_MAX, 13'd0));
      directed_rows.push_back(item_row(ACT_SET, 1'b0, 1'b0, 16'h0000));
      directed_rows.push_back(item_row(ACT_SET, 1'b1, 1'b1, 16'h0001));
      directed_rows.push_back(cfg_row(CFG_INPUT_MAX, 13'd7));
      directed_rows.push_back(cfg_row(CFG_MIN_WIDTH, 13'd1800));
      directed_rows.push_back(cfg_row(CFG_MAX_WIDTH, 13'd0));
      directed_rows.push_back(item_row(ACT_SET, 1'b0, 1'b1, 16'h0003));
      directed_rows.push_back(item_row(ACT_SET, 1'b1, 1'b1, 16'h0005));
      directed_rows.push_back(item_row(ACT_SET, 1'b1, 1'b1, 16'hFFFF));
      directed_rows.push_back(cfg_row(CFG_INPUT_MAX, 13'h1FFF));
      directed_rows.push_back(cfg_row(CFG_MIN_WIDTH, 13'h0000));
      directed_rows.push_back(cfg_row(CFG_MAX_WIDTH, 13'h1FFF));
      directed_rows.push_back(item_row(ACT_SET, 1'b0, 1'b1, 16'h1234));
      directed_rows.push_back(item_row(ACT_SET, 1'b1, 1'b0, 16'hAAAA));
      directed_rows.push_back(item_row(ACT_SET, 1'b0, 1'b1, 16'h5555));
      directed_rows.push_back(cfg_row(CFG_INVERT_FIRST, 13'd0));
      directed_rows.push_back(cfg_row(CFG_INVERT_SECOND, 13'd0));
      directed_rows.push_back(cfg_row(CFG_INPUT_MAX, INPUT_MAX_RESET));
      directed_rows.push_back(cfg_row(CFG_MIN_WIDTH, MIN_WIDTH_RESET));
      directed_rows.push_back(cfg_row(CFG_MAX_WIDTH, MAX_WIDTH_RESET));
      directed_rows.push_back(item_row(ACT_SET, 1'b0, 1'b1, 16'h0000));
      directed_rows.push_back(item_row(ACT_TICK, 1'b0, 1'b1, 16'h8000));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_cfg) begin
            write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
         end else begin
            send_item(directed_rows[i].act, directed_rows[i].chan, directed_rows[i].has_lvl,
                      directed_rows[i].lvl, directed_rows[i].typed, directed_rows[i].want);
         end
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph == 0) begin
            write_reg(CFG_INPUT_MAX, INPUT_MAX_RESET);
            write_reg(CFG_MIN_WIDTH, MIN_WIDTH_RESET);
            write_reg(CFG_MAX_WIDTH, MAX_WIDTH_RESET);
         end else begin
            write_reg(CFG_INPUT_MAX, pick_setting(1, 4096));
            write_reg(CFG_MIN_WIDTH, pick_setting(600, 2600));
            write_reg(CFG_MAX_WIDTH, pick_setting(600, 2600));
         end
         write_reg(CFG_INVERT_FIRST, CFG_W'($urandom_range(0, 8191)));
         write_reg(CFG_INVERT_SECOND, CFG_W'($urandom_range(0, 8191)));

         src_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 15;
         snk_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 15;
         if (ph == 1) begin
            src_gap_max = 0;
            snk_gap_max = 0;
         end
         // back-to-back items against a long receiver hold-off fill the block
         if (ph == 3) begin
            src_gap_max  = 0;
            hold_request = 1'b1;
         end

         repeat (ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 15) != 0) begin
               // tick: the other fields carry noise that the block ignores
               act = ACT_TICK;
               ch  = 1'($urandom());
               has = 1'($urandom());
               lvl = LEVEL_W'($urandom());
            end else begin
               act = ACT_SET;
               ch  = 1'($urandom());
               has = ($urandom_range(0, 3) != 0);
               if ($urandom_range(0, 1) == 0)
                  lvl = LEVEL_W'($urandom_range(0, int'(cfg_full_scale) + 1));
               else
                  lvl = LEVEL_W'($urandom());
            end
            send_item(act, ch, has, lvl, 1'b0, '0);
         end
      end

      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("two_channel_ppm_pulse_generator verification clean");
      end else begin
         $display("two_channel_ppm_pulse_generator verification failed");
      end
      $finish;
   end

   initial begin : rsp_side
      int gap;
      ppm_report_type got;
      ppm_report_type want;
      rsp_bus.ready <= 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         gap = $urandom_range(0, snk_gap_max);
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         got = '{rsp_bus.first_pin, rsp_bus.second_pin,
                 rsp_bus.first_width, rsp_bus.second_width};
         if (awaited_reports.size() == 0) begin
            if (fail_count < 10)
               $display("rsp transfer with nothing awaited: pins %0d/%0d widths %0d/%0d",
                        got.first_pin, got.second_pin, got.first_width, got.second_width);
            fail_count++;
         end else begin
            want = awaited_reports.pop_front();
            if (got != want) begin
               if (fail_count < 10)
                  $display("rsp mismatch: expected %0d/%0d %0d/%0d, got %0d/%0d %0d/%0d",
                           want.first_pin, want.second_pin, want.first_width,
                           want.second_width, got.first_pin, got.second_pin,
                           got.first_width, got.second_width);
               fail_count++;
            end
         end
      end
   end

   // no transfer on either channel for too long means the block hung
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("no transfer for %0d cycles", STALL_LIMIT);
         $display("two_channel_ppm_pulse_generator verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
